// ===== hw/rtl/time_ordered_event_queue_macros.svh =====
// Assertion macros shared by the event queue checker.
// Each macro expects clk_i and rst_ni in the enclosing scope.
`ifndef TIME_ORDERED_EVENT_QUEUE_MACROS_SVH
`define TIME_ORDERED_EVENT_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define TOEQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("event queue check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define TOEQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("event queue check failed");

`endif

// ===== hw/rtl/toeq_pkg.sv =====
// Types, constants and tag helpers for the time-ordered event queue.
// Used by toeq_cell, time_ordered_event_queue and toeq_checker.
`timescale 1ns / 1ps

package toeq_pkg;

  localparam int Depth = 16;
  localparam int TagW  = 16;
  localparam int CntW  = $clog2(Depth + 1);

  localparam logic OpInsert = 1'b0;
  localparam logic OpPop    = 1'b1;

  localparam logic [1:0] StInserted = 2'd0;
  localparam logic [1:0] StPopped   = 2'd1;
  localparam logic [1:0] StEmpty    = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] event_time;
    logic [15:0]        event_tag;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_time;
    logic [15:0]        popped_tag;
    logic [CntW-1:0]    entry_count;
  } out_t;

  typedef struct packed {
    logic signed [31:0] evt_time;
    logic [TagW-1:0]    evt_tag;
  } entry_t;

  // Broadcast from the top level to every cell in the chain.
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t new_entry;
  } cell_ctrl_t;

  function automatic logic [TagW-1:0] tag_store(input logic [15:0] g);
    logic [31:0]     w;
    logic [TagW-1:0] r;
    w = {16'b0, g};
    for (int i = 0; i < TagW; i++) begin
      r[i] = w[i];
    end
    return r;
  endfunction

  function automatic logic [15:0] tag_load(input logic [TagW-1:0] s);
    logic [31:0] w;
    w = '0;
    for (int i = 0; i < TagW; i++) begin
      w[i] = s[i];
    end
    return w[15:0];
  endfunction

endpackage

// ===== hw/rtl/toeq_cell.sv =====
// One slot of the sorted shift-register queue.
// Depends on toeq_pkg for the entry and control types.
`timescale 1ns / 1ps

module toeq_cell (
  input  logic                  clk_i,
  input  toeq_pkg::cell_ctrl_t  ctrl_i,
  input  logic                  occ_i,
  input  logic                  left_keep_i,
  input  toeq_pkg::entry_t      left_i,
  input  toeq_pkg::entry_t      right_i,
  output logic                  keep_o,
  output toeq_pkg::entry_t      entry_o
);

  toeq_pkg::entry_t entry_q, entry_d;

  // An occupied slot with an equal or earlier time stays put on insert.
  assign keep_o = occ_i && (entry_q.evt_time <= ctrl_i.new_entry.evt_time);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (keep_o) begin
        entry_d = entry_q;
      end else if (left_keep_i) begin
        entry_d = ctrl_i.new_entry;
      end else begin
        entry_d = left_i;
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== hw/rtl/time_ordered_event_queue.sv =====
// Time-ordered event queue: top level with the cell chain and output buffering.
// Depends on toeq_pkg and toeq_cell.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one request per
//   transaction: operation 0 inserts event_time/event_tag, operation 1 pops the
//   entry with the smallest time. Equal times leave in arrival order.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns one result
//   per request: status, popped time and tag (zero unless popped) and the count
//   of stored entries after the request.
//   Each accepted request's result is registered before it reaches the output.
//   Throughput is one request per cycle while in_stall_o is low: every cell
//   compares its own time with the incoming time in parallel and shifts by one
//   slot, so the cell update sets the rate.
//   An insert into a full queue is dropped with status full; a pop on an empty
//   queue reports status empty and changes nothing.
//   Reset empties the queue at once; no clearing pass is needed.
//   When the receiver stalls, the result is held in the output register and one
//   more result goes to a skid register; in_stall_o rises only while the skid
//   register is occupied.

module time_ordered_event_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  toeq_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output toeq_pkg::out_t out_data_o
);

  logic [toeq_pkg::CntW-1:0] count_q, count_d;
  logic                      out_valid_q, out_valid_d;
  logic                      skid_valid_q, skid_valid_d;
  toeq_pkg::out_t            out_q, out_d;
  toeq_pkg::out_t            skid_q, skid_d;
  toeq_pkg::out_t            result;
  toeq_pkg::cell_ctrl_t      ctrl;
  toeq_pkg::entry_t          entries [toeq_pkg::Depth];
  logic [toeq_pkg::Depth-1:0] keep;
  logic                      in_acc, out_fire, is_full, is_empty;

  assign in_acc   = in_valid_i && !skid_valid_q;
  assign out_fire = out_valid_q && !out_stall_i;
  assign is_full  = (count_q == toeq_pkg::CntW'(toeq_pkg::Depth));
  assign is_empty = (count_q == '0);

  assign ctrl.ins = in_acc && (in_data_i.operation == toeq_pkg::OpInsert) && !is_full;
  assign ctrl.pop = in_acc && (in_data_i.operation == toeq_pkg::OpPop) && !is_empty;
  assign ctrl.new_entry.evt_time = in_data_i.event_time;
  assign ctrl.new_entry.evt_tag  = toeq_pkg::tag_store(in_data_i.event_tag);

  for (genvar g = 0; g < toeq_pkg::Depth; g++) begin : gen_cell
    logic             occ, left_keep;
    toeq_pkg::entry_t left_e, right_e;

    assign occ = (toeq_pkg::CntW'(g) < count_q);

    if (g == 0) begin : gen_head
      assign left_keep = 1'b1;
      assign left_e    = ctrl.new_entry;
    end else begin : gen_body
      assign left_keep = keep[g-1];
      assign left_e    = entries[g-1];
    end

    if (g == toeq_pkg::Depth - 1) begin : gen_tail
      assign right_e = entries[g];
    end else begin : gen_mid
      assign right_e = entries[g+1];
    end

    toeq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ),
      .left_keep_i (left_keep),
      .left_i      (left_e),
      .right_i     (right_e),
      .keep_o      (keep[g]),
      .entry_o     (entries[g])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    result.popped_time = '0;
    result.popped_tag  = '0;
    result.entry_count = count_d;
    if (in_data_i.operation == toeq_pkg::OpInsert) begin
      result.status = is_full ? toeq_pkg::StFull : toeq_pkg::StInserted;
    end else if (is_empty) begin
      result.status = toeq_pkg::StEmpty;
    end else begin
      result.status      = toeq_pkg::StPopped;
      result.popped_time = entries[0].evt_time;
      result.popped_tag  = toeq_pkg::tag_load(entries[0].evt_tag);
    end
  end

  // Output register backed by a one-deep skid register.
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = result;
        out_valid_d = in_acc;
      end
    end else if (in_acc) begin
      skid_d       = result;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/toeq_checker.sv =====
// Port-level checker for the time-ordered event queue, bound to the top level.
// Depends on toeq_pkg and time_ordered_event_queue_macros.svh.
`timescale 1ns / 1ps
`include "time_ordered_event_queue_macros.svh"

module toeq_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input toeq_pkg::out_t out_data_o
);

  logic                      out_held;
  logic                      empty_seen;
  logic                      full_seen;
  logic                      other_seen;
  logic                      zero_payload;
  logic [toeq_pkg::CntW-1:0] full_count;

  assign out_held     = out_valid_o && out_stall_i;
  assign empty_seen   = out_valid_o && (out_data_o.status == toeq_pkg::StEmpty);
  assign full_seen    = out_valid_o && (out_data_o.status == toeq_pkg::StFull);
  assign other_seen   = out_valid_o && (out_data_o.status != toeq_pkg::StPopped);
  assign zero_payload = (out_data_o.popped_time == '0) && (out_data_o.popped_tag == '0);
  assign full_count   = toeq_pkg::CntW'(toeq_pkg::Depth);

  `TOEQ_ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(out_data_o))

  `TOEQ_ASSERT_NOW(a_stall_cause, $rose(in_stall_o), $past(out_held))

  `TOEQ_ASSERT_NOW(a_empty_count, empty_seen, out_data_o.entry_count == '0)

  `TOEQ_ASSERT_NOW(a_full_count, full_seen, out_data_o.entry_count == full_count)

  `TOEQ_ASSERT_NOW(a_zero_payload, other_seen, zero_payload)

endmodule

bind time_ordered_event_queue toeq_checker u_toeq_checker (.*);
